// ===== hdl/lrt_pkg.sv =====
// Shared types and constants for the LRU replacement tracker.
package lrt_pkg;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_EVICT  = 2'd1,
    OP_ERASE  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic exec;
  } lrt_cmd_t;

endpackage

// ===== hdl/lrt_ctrl.sv =====
// Controller for the LRU replacement tracker: input capture, execution and output hand-off.
module lrt_ctrl
  import lrt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output lrt_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign cmd.load = s_tvalid && s_tready;
  assign cmd.exec = (state == ST_EXEC) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.exec) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A result may only be overwritten once the previous one has been taken.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !cmd.exec)
    else $error("result overwritten before its transfer");

  // Execution is always preceded by a captured item.
  assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_EXEC) |-> $past(cmd.load))
    else $error("execution entered without a captured item");

  // No new item is taken while one is being executed.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !cmd.load)
    else $error("item captured during execution");

endmodule

// ===== hdl/lrt_datapath.sv =====
// Datapath for the LRU replacement tracker: ordered key array, presence bits, count and result.
module lrt_datapath
  import lrt_pkg::*;
#(
  parameter int FRAMES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  lrt_cmd_t            cmd,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [KEY_W-1:0]    in_key,
  output logic                res_ok,
  output logic [KEY_W-1:0]    res_victim_key,
  output logic [COUNT_W-1:0]  res_count
);

  localparam int KEY_SPACE = 2 ** KEY_W;
  localparam int SLOTS     = (FRAMES < KEY_SPACE) ? FRAMES : KEY_SPACE;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);

  logic [KEY_W-1:0] order [SLOTS];
  logic [SLOTS-1:0] present;
  logic [CNT_W-1:0] count;

  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] key;

  logic [KEY_W-1:0] order_next [SLOTS];
  logic [SLOTS-1:0] present_next;
  logic [CNT_W-1:0] count_next;
  logic             ok_next;
  logic [KEY_W-1:0] victim_next;

  logic             in_range;
  logic [IDX_W-1:0] key_idx;
  logic             key_present;
  logic [SLOTS-1:0] hit;
  logic [SLOTS-1:0] rm;
  logic [SLOTS-1:0] shift;
  logic [CNT_W-1:0] count_rm;

  assign in_range    = int'(key) < FRAMES;
  assign key_idx     = key[IDX_W-1:0];
  assign key_present = in_range && present[key_idx];

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = (CNT_W'(i) < count) && (order[i] == key);
    end
  end

  always_comb begin
    rm = '0;
    case (op)
      OP_INSERT: begin
        if (key_present) begin
          rm = hit;
        end
      end
      OP_EVICT: begin
        if (count != '0) begin
          rm[0] = 1'b1;
        end
      end
      OP_ERASE: begin
        if (key_present) begin
          rm = hit;
        end
      end
      default: begin
        rm = '0;
      end
    endcase
  end

  always_comb begin
    shift[0] = rm[0];
    for (int i = 1; i < SLOTS; i++) begin
      shift[i] = shift[i-1] | rm[i];
    end
  end

  assign count_rm = count - CNT_W'(|rm);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      order_next[i] = order[i];
      if (shift[i] && (i + 1 < SLOTS)) begin
        order_next[i] = order[(i + 1) % SLOTS];
      end
    end
    present_next = present;
    count_next   = count;
    ok_next      = 1'b0;
    victim_next  = '0;
    case (op)
      OP_INSERT: begin
        if (in_range && (count_rm < CNT_W'(SLOTS))) begin
          order_next[count_rm[IDX_W-1:0]] = key;
          present_next[key_idx]           = 1'b1;
          count_next                      = count_rm + CNT_W'(1);
          ok_next                         = 1'b1;
        end else begin
          count_next = count_rm;
        end
      end
      OP_EVICT: begin
        if (count != '0) begin
          victim_next = order[0];
          if (int'(order[0]) < FRAMES) begin
            present_next[order[0][IDX_W-1:0]] = 1'b0;
          end
          count_next = count_rm;
          ok_next    = 1'b1;
        end
      end
      OP_ERASE: begin
        if (key_present) begin
          present_next[key_idx] = 1'b0;
          count_next            = count_rm;
          ok_next               = 1'b1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_opcode;
      key <= in_key;
    end
    if (cmd.exec) begin
      order          <= order_next;
      res_ok         <= ok_next;
      res_victim_key <= victim_next;
      res_count      <= COUNT_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      count   <= '0;
    end else if (cmd.exec) begin
      present <= present_next;
      count   <= count_next;
    end
  end

  // The count never exceeds the number of slots.
  assert property (@(posedge clk) disable iff (rst)
    int'(count) <= SLOTS)
    else $error("entry count beyond capacity");

  // Each tracked key has exactly one presence bit set.
  assert property (@(posedge clk) disable iff (rst)
    $countones(present) == int'(count))
    else $error("presence bits disagree with entry count");

  // A successful insert leaves its key marked present.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && ok_next && (op == OP_INSERT)) |=> present[$past(key_idx)])
    else $error("inserted key not marked present");

endmodule

// ===== hdl/lru_replacement_tracker.sv =====
// Top level of the LRU replacement tracker: stream ports, controller and datapath.
//
// Each transfer on the input stream carries one operation (insert or touch a key, evict the
// least recent key, erase a key) and produces exactly one result transfer holding the
// success flag, the evicted key and the entry count after the operation. An item is captured
// and then executed by a parallel compare-and-shift over the ordered key array, so the block
// takes no new item until the current one has executed; a result not yet taken holds
// execution of the following item. The presence bits are cleared by reset directly, so the
// block is ready as soon as reset is released.
module lru_replacement_tracker
  import lrt_pkg::*;
#(
  parameter int FRAMES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // opcode[1:0], key[5:2], zero padding
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // ok[0], victim_key[4:1], count[9:5], zero padding
);

  lrt_cmd_t           cmd;
  logic               res_ok;
  logic [KEY_W-1:0]   res_victim_key;
  logic [COUNT_W-1:0] res_count;

  lrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lrt_datapath #(
    .FRAMES (FRAMES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .in_opcode      (s_tdata[OP_W-1:0]),
    .in_key         (s_tdata[OP_W+KEY_W-1:OP_W]),
    .res_ok         (res_ok),
    .res_victim_key (res_victim_key),
    .res_count      (res_count)
  );

  assign m_tdata = {{(M_DATA_W-1-KEY_W-COUNT_W){1'b0}}, res_count, res_victim_key, res_ok};

endmodule

// ===== sim/lru_replacement_tracker_tb.sv =====
// Self-checking testbench for the LRU replacement tracker with a recency-order scoreboard.
module lru_replacement_tracker_tb
  import lrt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES = 16;

  typedef struct packed {
    logic               ok;
    logic [KEY_W-1:0]   victim;
    logic [COUNT_W-1:0] count;
  } lru_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // opcode[1:0], key[5:2], zero padding
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // ok[0], victim_key[4:1], count[9:5], zero padding

  logic [KEY_W-1:0]  lru_order [FRAMES];
  logic [FRAMES-1:0] lru_present = '0;
  int unsigned       lru_count = 0;
  lru_result_t       result_q [$];
  int                errors = 0;
  bit                quiet = 1'b0;
  int                hold_len = 0;

  lru_replacement_tracker #(
    .FRAMES(FRAMES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned slot_of(logic [KEY_W-1:0] key);
    int unsigned i;
    for (i = 0; i < lru_count; i++) begin
      if (lru_order[i] == key) return i;
    end
    return lru_count;
  endfunction

  function automatic void drop_slot(int unsigned p);
    int unsigned i;
    if (lru_count == 0 || p >= lru_count) return;
    for (i = p; i + 1 < lru_count; i++) lru_order[i] = lru_order[i + 1];
    lru_count--;
  endfunction

  function automatic lru_result_t apply_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    lru_result_t r;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (lru_present[key]) drop_slot(slot_of(key));
        if (lru_count < FRAMES) begin
          lru_order[lru_count] = key;
          lru_count++;
          lru_present[key] = 1'b1;
          r.ok = 1'b1;
        end
      end
      OP_EVICT: begin
        if (lru_count > 0) begin
          r.victim = lru_order[0];
          drop_slot(0);
          lru_present[r.victim] = 1'b0;
          r.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        if (lru_present[key]) begin
          drop_slot(slot_of(key));
          lru_present[key] = 1'b0;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = lru_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(bit tracked);
    if (tracked && lru_count > 0) return lru_order[$urandom_range(0, lru_count - 1)];
    return KEY_W'($urandom_range(0, FRAMES - 1));
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, key, op};
    do @(posedge clk); while (!s_tready);
    result_q.push_back(apply_op(op, key));
  endtask

  task automatic report(input string field, input int exp_val, input int act_val);
    $display("%0t ns: %s expected %0d actual %0d", $time, field, exp_val, act_val);
    errors++;
  endtask

  initial begin
    int          stall;
    lru_result_t exp_res;
    lru_result_t act_res;
    wait (!rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 16);
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      act_res.ok     = m_tdata[0];
      act_res.victim = m_tdata[4:1];
      act_res.count  = m_tdata[9:5];
      if (result_q.size() == 0) begin
        $display("%0t ns: unexpected result transfer, expected none actual %h", $time,
                 m_tdata);
        errors++;
      end else begin
        exp_res = result_q.pop_front();
        if (act_res.ok !== exp_res.ok) report("ok", exp_res.ok, act_res.ok);
        if (act_res.victim !== exp_res.victim)
          report("victim_key", exp_res.victim, act_res.victim);
        if (act_res.count !== exp_res.count) report("count", exp_res.count, act_res.count);
      end
    end
  end

  task automatic test_empty_set();
    send_op(OP_EVICT, 4'd15);
    send_op(OP_ERASE, 4'd0);
    send_op(OP_ERASE, 4'd15);
    send_op(OP_UNUSED, 4'd15);
  endtask

  task automatic test_insert_touch();
    send_op(OP_INSERT, 4'd0);
    send_op(OP_INSERT, 4'd15);
    send_op(OP_INSERT, 4'd7);
    send_op(OP_INSERT, 4'd0);
    send_op(OP_UNUSED, 4'd7);
  endtask

  task automatic test_erase();
    send_op(OP_ERASE, 4'd7);
    send_op(OP_ERASE, 4'd7);
  endtask

  task automatic test_evict_order();
    send_op(OP_EVICT, 4'd0);
    send_op(OP_EVICT, 4'd10);
    send_op(OP_EVICT, 4'd5);
  endtask

  task automatic test_full_set();
    logic [KEY_W-1:0] perm [FRAMES];
    logic [KEY_W-1:0] tmp;
    int               i;
    int               j;
    for (i = 0; i < FRAMES; i++) perm[i] = KEY_W'(i);
    for (i = FRAMES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (i = 0; i < FRAMES; i++) send_op(OP_INSERT, perm[i]);
    send_op(OP_UNUSED, 4'd3);
    for (i = 0; i < FRAMES; i++) send_op(OP_INSERT, pick_key(1'b1));
    for (i = 0; i <= FRAMES; i++) send_op(OP_EVICT, pick_key(1'b0));
  endtask

  task automatic test_backpressure();
    int i;
    quiet = 1'b1;
    hold_len = 200;
    for (i = 0; i < 30; i++) send_op(($urandom_range(0, 2) == 0) ? OP_EVICT : OP_INSERT,
                                     pick_key(1'b0));
    quiet = 1'b0;
  endtask

  task automatic test_random(input int n_items);
    int               i;
    int               r;
    int               ins;
    int               ev;
    int               er;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    for (i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        quiet = ((i / 50) % 5 == 4);
        case ((i / 50) % 4)
          0:       begin ins = 70; ev = 13; er = 13; end
          1:       begin ins = 25; ev = 50; er = 21; end
          2:       begin ins = 45; ev = 25; er = 26; end
          default: begin ins = 40; ev = 16; er = 40; end
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < ins) begin
        op  = OP_INSERT;
        key = pick_key($urandom_range(0, 99) < 40);
      end else if (r < ins + ev) begin
        op  = OP_EVICT;
        key = pick_key(1'b0);
      end else if (r < ins + ev + er) begin
        op  = OP_ERASE;
        key = pick_key($urandom_range(0, 99) < 75);
      end else begin
        op  = OP_UNUSED;
        key = pick_key(1'b0);
      end
      send_op(op, key);
    end
    quiet = 1'b0;
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_set();
    test_insert_touch();
    test_erase();
    test_evict_order();
    test_full_set();
    test_backpressure();
    test_random(1350);
    @(negedge clk);
    s_tvalid <= 1'b0;
    for (n = 0; n < 5000 && result_q.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (result_q.size() != 0) begin
      $display("%0t ns: results outstanding, expected 0 actual %0d", $time, result_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
